### rtl/mfp_pkg.sv
// Types and constants for the MQTT frame parser.
// No dependencies; imported by mfp_step and mqtt_frame_parser.
package mfp_pkg;

	localparam logic [2:0] PH_IDLE    = 3'd0;
	localparam logic [2:0] PH_LEN     = 3'd1;
	localparam logic [2:0] PH_HDR     = 3'd2;
	localparam logic [2:0] PH_TLEN    = 3'd3;
	localparam logic [2:0] PH_TOPIC   = 3'd4;
	localparam logic [2:0] PH_PID     = 3'd5;
	localparam logic [2:0] PH_PAYLOAD = 3'd6;

	localparam logic [3:0] CMD_CONNACK   = 4'd2;
	localparam logic [3:0] CMD_PUBLISH   = 4'd3;
	localparam logic [3:0] CMD_PUBACK    = 4'd4;
	localparam logic [3:0] CMD_PUBREC    = 4'd5;
	localparam logic [3:0] CMD_PUBREL    = 4'd6;
	localparam logic [3:0] CMD_PUBCOMP   = 4'd7;
	localparam logic [3:0] CMD_SUBSCRIBE = 4'd8;
	localparam logic [3:0] CMD_SUBACK    = 4'd9;

	localparam logic [2:0] CLS_FIXED   = 3'd0;
	localparam logic [2:0] CLS_LENGTH  = 3'd1;
	localparam logic [2:0] CLS_VARHDR  = 3'd2;
	localparam logic [2:0] CLS_TOPIC   = 3'd3;
	localparam logic [2:0] CLS_PAYLOAD = 3'd4;

	localparam logic [2:0] LEN_MAX_BYTES = 3'd4;

	typedef struct packed {
		logic [2:0]  phase;
		logic [3:0]  command;
		logic [1:0]  qos;
		logic [27:0] len_accum;
		logic [2:0]  len_count;
		logic [27:0] bytes_left;
		logic        field_count;
		logic [15:0] id_value;
		logic [15:0] tlen_value;
		logic [15:0] topic_left;
		logic [7:0]  ack_code;
	} parse_state_t;

	typedef struct packed {
		logic [2:0]  byte_class;
		logic [7:0]  data_byte;
		logic [3:0]  packet_kind;
		logic [1:0]  qos_level;
		logic [27:0] remaining_length;
		logic [15:0] packet_id;
		logic [7:0]  connack_code;
		logic [15:0] topic_size;
		logic        header_done;
		logic        frame_end;
		logic        frame_error;
	} parse_result_t;

endpackage

### rtl/mqtt_frame_parser.sv
// MQTT 3.1 fixed and variable header parser, top level.
// Depends on mfp_pkg and mfp_step.
//
// Takes one stream byte per transfer and returns one tagged result per byte,
// in order. A byte lands in an input register, goes through one level of
// header-decode logic and lands in the result register, which drives result
// valid. Both registers advance together, so the block sustains one byte per
// clock as long as results are taken; a stalled result holds the result
// register and then the input register. Parse state updates when a byte moves
// into the result register. No clearing pass.
module mqtt_frame_parser import mfp_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        byte_valid,
	output logic        byte_ready,
	input  logic [7:0]  stream_byte,
	output logic        result_valid,
	input  logic        result_ready,
	output logic [2:0]  byte_class,
	output logic [7:0]  data_byte,
	output logic [3:0]  packet_kind,
	output logic [1:0]  qos_level,
	output logic [27:0] remaining_length,
	output logic [15:0] packet_id,
	output logic [7:0]  connack_code,
	output logic [15:0] topic_size,
	output logic        header_done,
	output logic        frame_end,
	output logic        frame_error
);

	logic          valid_s1;
	logic [7:0]    byte_s1;
	logic          valid_s2;
	parse_result_t res_s2;
	parse_state_t  state_q;
	parse_state_t  state_next;
	parse_result_t res_next;
	logic          advance;

	assign advance    = valid_s1 && (!valid_s2 || result_ready);
	assign byte_ready = !valid_s1 || advance;

	mfp_step u_step (
		.cur         (state_q),
		.stream_byte (byte_s1),
		.nxt         (state_next),
		.res         (res_next)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			state_q  <= '0;
		end else begin
			if (byte_ready) begin
				valid_s1 <= byte_valid;
			end
			if (advance) begin
				valid_s2 <= 1'b1;
				state_q  <= state_next;
			end else if (result_ready) begin
				valid_s2 <= 1'b0;
			end
		end
	end

	// payload registers: load on transfer, hold otherwise
	always_ff @(posedge clk) begin
		if (byte_valid && byte_ready) begin
			byte_s1 <= stream_byte;
		end
		if (advance) begin
			res_s2 <= res_next;
		end
	end

	assign result_valid     = valid_s2;
	assign byte_class       = res_s2.byte_class;
	assign data_byte        = res_s2.data_byte;
	assign packet_kind      = res_s2.packet_kind;
	assign qos_level        = res_s2.qos_level;
	assign remaining_length = res_s2.remaining_length;
	assign packet_id        = res_s2.packet_id;
	assign connack_code     = res_s2.connack_code;
	assign topic_size       = res_s2.topic_size;
	assign header_done      = res_s2.header_done;
	assign frame_end        = res_s2.frame_end;
	assign frame_error      = res_s2.frame_error;

endmodule

### rtl/mfp_step.sv
// Next-state and result logic for one stream byte of the MQTT frame parser.
// Depends on mfp_pkg.
module mfp_step import mfp_pkg::*; (
	input  parse_state_t  cur,
	input  logic [7:0]    stream_byte,
	output parse_state_t  nxt,
	output parse_result_t res
);

	logic [2:0]  first_ph;
	logic [27:0] accum_new;
	logic [27:0] left_dec;
	logic [15:0] topic_dec;
	logic [15:0] tlen_new;
	logic [2:0]  cls;
	logic        hd;
	logic        fe;
	logic        err;

	always_comb begin
		case (cur.command)
			CMD_CONNACK, CMD_PUBACK, CMD_PUBREC, CMD_PUBREL, CMD_PUBCOMP,
			CMD_SUBSCRIBE, CMD_SUBACK: first_ph = PH_HDR;
			CMD_PUBLISH: first_ph = PH_TLEN;
			default: first_ph = PH_PAYLOAD;
		endcase
	end

	// place the 7-bit length group by its position in the varint
	always_comb begin
		accum_new = cur.len_accum;
		case (cur.len_count[1:0])
			2'd0: accum_new[6:0]   = cur.len_accum[6:0]   | stream_byte[6:0];
			2'd1: accum_new[13:7]  = cur.len_accum[13:7]  | stream_byte[6:0];
			2'd2: accum_new[20:14] = cur.len_accum[20:14] | stream_byte[6:0];
			default: accum_new[27:21] = cur.len_accum[27:21] | stream_byte[6:0];
		endcase
	end

	assign left_dec  = (cur.bytes_left != 28'd0) ? cur.bytes_left - 28'd1 : 28'd0;
	assign topic_dec = (cur.topic_left != 16'd0) ? cur.topic_left - 16'd1 : 16'd0;
	assign tlen_new  = {cur.tlen_value[7:0], stream_byte};

	always_comb begin
		nxt = cur;
		cls = CLS_PAYLOAD;
		hd  = 1'b0;
		fe  = 1'b0;
		err = 1'b0;
		if (cur.phase == PH_IDLE) begin
			cls             = CLS_FIXED;
			nxt             = '0;
			nxt.command     = stream_byte[7:4];
			nxt.qos         = stream_byte[2:1];
			nxt.phase       = PH_LEN;
		end else if (cur.phase == PH_LEN) begin
			cls = CLS_LENGTH;
			if (cur.len_count >= LEN_MAX_BYTES) begin
				err       = 1'b1;
				fe        = 1'b1;
				nxt.phase = PH_IDLE;
			end else begin
				nxt.len_accum = accum_new;
				nxt.len_count = cur.len_count + 3'd1;
				if (!stream_byte[7]) begin
					nxt.bytes_left = accum_new;
					if (accum_new == 28'd0) begin
						fe        = 1'b1;
						err       = (first_ph != PH_PAYLOAD);
						nxt.phase = PH_IDLE;
					end else begin
						nxt.phase = first_ph;
					end
				end
			end
		end else begin
			nxt.bytes_left = left_dec;
			case (cur.phase)
				PH_HDR: begin
					cls = CLS_VARHDR;
					if (cur.command == CMD_CONNACK) begin
						if (cur.field_count) nxt.ack_code = stream_byte;
					end else begin
						nxt.id_value = {cur.id_value[7:0], stream_byte};
					end
					if (cur.field_count) begin
						nxt.field_count = 1'b0;
						hd              = 1'b1;
						nxt.phase       = PH_PAYLOAD;
					end else begin
						nxt.field_count = 1'b1;
					end
				end
				PH_TLEN: begin
					cls            = CLS_VARHDR;
					nxt.tlen_value = tlen_new;
					if (cur.field_count) begin
						nxt.field_count = 1'b0;
						nxt.topic_left  = tlen_new;
						if (tlen_new != 16'd0) begin
							nxt.phase = PH_TOPIC;
						end else if (cur.qos != 2'd0) begin
							nxt.phase = PH_PID;
						end else begin
							hd        = 1'b1;
							nxt.phase = PH_PAYLOAD;
						end
					end else begin
						nxt.field_count = 1'b1;
					end
				end
				PH_TOPIC: begin
					cls            = CLS_TOPIC;
					nxt.topic_left = topic_dec;
					if (topic_dec == 16'd0) begin
						if (cur.qos != 2'd0) begin
							nxt.phase = PH_PID;
						end else begin
							hd        = 1'b1;
							nxt.phase = PH_PAYLOAD;
						end
					end
				end
				PH_PID: begin
					cls          = CLS_VARHDR;
					nxt.id_value = {cur.id_value[7:0], stream_byte};
					if (cur.field_count) begin
						nxt.field_count = 1'b0;
						hd              = 1'b1;
						nxt.phase       = PH_PAYLOAD;
					end else begin
						nxt.field_count = 1'b1;
					end
				end
				default: begin
					cls       = CLS_PAYLOAD;
					nxt.phase = PH_PAYLOAD;
				end
			endcase
			// counted end of frame; resync on the next byte
			if (left_dec == 28'd0) begin
				fe        = 1'b1;
				err       = (nxt.phase != PH_PAYLOAD);
				nxt.phase = PH_IDLE;
			end
		end
	end

	always_comb begin
		res.byte_class       = cls;
		res.data_byte        = stream_byte;
		res.packet_kind      = nxt.command;
		res.qos_level        = nxt.qos;
		res.remaining_length = nxt.len_accum;
		res.packet_id        = nxt.id_value;
		res.connack_code     = nxt.ack_code;
		res.topic_size       = nxt.tlen_value;
		res.header_done      = hd;
		res.frame_end        = fe;
		res.frame_error      = err;
	end

endmodule

### sim/tb_mqtt_frame_parser.sv
// Self-checking testbench for mqtt_frame_parser: a directed byte table, then random frames.
// Depends on mfp_pkg and the parser RTL; results are checked by an in-bench byte decoder.
module tb_mqtt_frame_parser;
	import mfp_pkg::*;

	typedef struct {
		logic [7:0]    b;
		bit            pinned;
		parse_result_t res;
	} row_t;

	localparam int DIR_ROWS = 25;
	localparam int RANDOM_BYTES = 650;

	logic        clk;
	logic        arst_n = 1'b0;
	logic        byte_valid = 1'b0;
	logic        byte_ready;
	logic [7:0]  stream_byte = 8'h00;
	logic        result_valid;
	logic        result_ready = 1'b0;
	logic [2:0]  byte_class;
	logic [7:0]  data_byte;
	logic [3:0]  packet_kind;
	logic [1:0]  qos_level;
	logic [27:0] remaining_length;
	logic [15:0] packet_id;
	logic [7:0]  connack_code;
	logic [15:0] topic_size;
	logic        header_done;
	logic        frame_end;
	logic        frame_error;

	// decoder state
	logic [2:0]  st_phase = PH_IDLE;
	logic [3:0]  st_cmd = '0;
	logic [1:0]  st_qos = '0;
	logic [27:0] st_len = '0;
	logic [2:0]  st_len_cnt = '0;
	logic [27:0] st_left = '0;
	logic        st_field = 1'b0;
	logic [15:0] st_id = '0;
	logic [15:0] st_tlen = '0;
	logic [15:0] st_tleft = '0;
	logic [7:0]  st_code = '0;

	parse_result_t parse_due [$];
	parse_result_t want;
	logic [7:0]    frame_bytes [$];
	int            mismatches = 0;
	bit            no_idle = 1'b0;
	bit            hold_req = 1'b0;

	row_t dir_rows [0:DIR_ROWS-1] = '{
		'{8'hFF, 1'b1, '{CLS_FIXED, 8'hFF, 4'hF, 2'd3, 28'd0, 16'd0, 8'd0, 16'd0,
			1'b0, 1'b0, 1'b0}},
		'{8'h00, 1'b1, '{CLS_LENGTH, 8'h00, 4'hF, 2'd3, 28'd0, 16'd0, 8'd0, 16'd0,
			1'b0, 1'b1, 1'b0}},
		'{8'h20, 1'b0, '0},
		'{8'h00, 1'b1, '{CLS_LENGTH, 8'h00, CMD_CONNACK, 2'd0, 28'd0, 16'd0, 8'd0, 16'd0,
			1'b0, 1'b1, 1'b1}},
		'{8'h01, 1'b0, '0},
		'{8'hFF, 1'b0, '0},
		'{8'hFF, 1'b0, '0},
		'{8'hFF, 1'b0, '0},
		'{8'hFF, 1'b0, '0},
		'{8'h80, 1'b1, '{CLS_LENGTH, 8'h80, 4'h0, 2'd0, 28'hFFFFFFF, 16'd0, 8'd0, 16'd0,
			1'b0, 1'b1, 1'b1}},
		'{8'h20, 1'b0, '0},
		'{8'h02, 1'b0, '0},
		'{8'h01, 1'b0, '0},
		'{8'h05, 1'b0, '0},
		'{8'h32, 1'b0, '0},
		'{8'h06, 1'b0, '0},
		'{8'h00, 1'b0, '0},
		'{8'h02, 1'b0, '0},
		'{8'h61, 1'b0, '0},
		'{8'h62, 1'b0, '0},
		'{8'h12, 1'b0, '0},
		'{8'h34, 1'b0, '0},
		'{8'h40, 1'b0, '0},
		'{8'h01, 1'b0, '0},
		'{8'hAB, 1'b1, '{CLS_VARHDR, 8'hAB, CMD_PUBACK, 2'd0, 28'd1, 16'h00AB, 8'd0, 16'd0,
			1'b0, 1'b1, 1'b1}}
	};

	mqtt_frame_parser uut (
		.clk(clk),
		.arst_n(arst_n),
		.byte_valid(byte_valid),
		.byte_ready(byte_ready),
		.stream_byte(stream_byte),
		.result_valid(result_valid),
		.result_ready(result_ready),
		.byte_class(byte_class),
		.data_byte(data_byte),
		.packet_kind(packet_kind),
		.qos_level(qos_level),
		.remaining_length(remaining_length),
		.packet_id(packet_id),
		.connack_code(connack_code),
		.topic_size(topic_size),
		.header_done(header_done),
		.frame_end(frame_end),
		.frame_error(frame_error)
	);

	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	function automatic logic [2:0] body_phase(input logic [3:0] c);
		if (c == CMD_CONNACK || (c >= CMD_PUBACK && c <= CMD_PUBCOMP) ||
				c == CMD_SUBSCRIBE || c == CMD_SUBACK)
			return PH_HDR;
		if (c == CMD_PUBLISH)
			return PH_TLEN;
		return PH_PAYLOAD;
	endfunction

	function automatic parse_result_t decode_byte(input logic [7:0] b);
		parse_result_t r;
		logic [2:0]    nxt;
		r = '0;
		r.byte_class = CLS_PAYLOAD;
		r.data_byte = b;
		if (st_phase == PH_IDLE) begin
			r.byte_class = CLS_FIXED;
			st_cmd = b[7:4];
			st_qos = b[2:1];
			st_len = '0;
			st_len_cnt = '0;
			st_left = '0;
			st_field = 1'b0;
			st_id = '0;
			st_tlen = '0;
			st_tleft = '0;
			st_code = '0;
			st_phase = PH_LEN;
		end else if (st_phase == PH_LEN) begin
			r.byte_class = CLS_LENGTH;
			if (st_len_cnt >= LEN_MAX_BYTES) begin
				// fifth length byte: drop it and end the frame
				r.frame_end = 1'b1;
				r.frame_error = 1'b1;
				st_phase = PH_IDLE;
			end else begin
				st_len = st_len | (28'(b[6:0]) << (7 * st_len_cnt));
				st_len_cnt = st_len_cnt + 3'd1;
				if (!b[7]) begin
					nxt = body_phase(st_cmd);
					st_left = st_len;
					if (st_len == 0) begin
						r.frame_end = 1'b1;
						r.frame_error = (nxt != PH_PAYLOAD);
						st_phase = PH_IDLE;
					end else begin
						st_phase = nxt;
					end
				end
			end
		end else begin
			if (st_left != 0)
				st_left = st_left - 28'd1;
			case (st_phase)
				PH_HDR: begin
					r.byte_class = CLS_VARHDR;
					if (st_cmd == CMD_CONNACK) begin
						if (st_field)
							st_code = b;
					end else begin
						st_id = {st_id[7:0], b};
					end
					if (st_field) begin
						st_field = 1'b0;
						r.header_done = 1'b1;
						st_phase = PH_PAYLOAD;
					end else begin
						st_field = 1'b1;
					end
				end
				PH_TLEN: begin
					r.byte_class = CLS_VARHDR;
					st_tlen = {st_tlen[7:0], b};
					if (st_field) begin
						st_field = 1'b0;
						st_tleft = st_tlen;
						if (st_tleft != 0) begin
							st_phase = PH_TOPIC;
						end else if (st_qos != 0) begin
							st_phase = PH_PID;
						end else begin
							r.header_done = 1'b1;
							st_phase = PH_PAYLOAD;
						end
					end else begin
						st_field = 1'b1;
					end
				end
				PH_TOPIC: begin
					r.byte_class = CLS_TOPIC;
					if (st_tleft != 0)
						st_tleft = st_tleft - 16'd1;
					if (st_tleft == 0) begin
						if (st_qos != 0) begin
							st_phase = PH_PID;
						end else begin
							r.header_done = 1'b1;
							st_phase = PH_PAYLOAD;
						end
					end
				end
				PH_PID: begin
					r.byte_class = CLS_VARHDR;
					st_id = {st_id[7:0], b};
					if (st_field) begin
						st_field = 1'b0;
						r.header_done = 1'b1;
						st_phase = PH_PAYLOAD;
					end else begin
						st_field = 1'b1;
					end
				end
				default: begin
					st_phase = PH_PAYLOAD;
				end
			endcase
			// counted end of frame: resync on the next byte
			if (st_left == 0) begin
				r.frame_end = 1'b1;
				r.frame_error = (st_phase != PH_PAYLOAD);
				st_phase = PH_IDLE;
			end
		end
		r.packet_kind = st_cmd;
		r.qos_level = st_qos;
		r.remaining_length = st_len;
		r.packet_id = st_id;
		r.connack_code = st_code;
		r.topic_size = st_tlen;
		return r;
	endfunction

	// Offer one byte, hold it until the transfer, then log its expected result.
	task automatic put_byte(input logic [7:0] b, input bit pinned, input parse_result_t pin_res);
		parse_result_t r;
		if (!no_idle && $urandom_range(0, 7) == 0) begin
			byte_valid <= 1'b0;
			repeat ($urandom_range(1, 19)) @(posedge clk);
		end
		byte_valid <= 1'b1;
		stream_byte <= b;
		do @(posedge clk); while (!byte_ready);
		r = decode_byte(b);
		if (pinned)
			r = pin_res;
		parse_due.push_back(r);
	endtask

	task automatic drain_results();
		byte_valid <= 1'b0;
		do @(posedge clk); while (parse_due.size() != 0);
	endtask

	// Build one frame: mostly well formed, some short, over-long or with a bad topic length.
	task automatic make_frame();
		logic [3:0] c;
		logic [3:0] fl;
		logic [7:0] body [$];
		int         sel;
		int         n_topic;
		int         blen;
		int         extra;
		int         k;
		sel = $urandom_range(0, 99);
		if ($urandom_range(0, 1) == 1)
			c = 4'($urandom_range(CMD_CONNACK, CMD_SUBACK));
		else
			c = 4'($urandom_range(0, 15));
		fl = 4'($urandom_range(0, 15));
		frame_bytes.push_back({c, fl});
		if (sel < 8) begin
			repeat (4) frame_bytes.push_back(8'h80 | 8'($urandom_range(0, 127)));
			frame_bytes.push_back(8'($urandom_range(0, 255)));
			return;
		end
		if (body_phase(c) == PH_HDR) begin
			repeat (2) body.push_back(8'($urandom_range(0, 255)));
		end else if (c == CMD_PUBLISH) begin
			n_topic = $urandom_range(0, 6);
			body.push_back(8'h00);
			body.push_back(8'(n_topic));
			repeat (n_topic) body.push_back(8'($urandom_range(0, 255)));
			if (fl[2:1] != 2'd0)
				repeat (2) body.push_back(8'($urandom_range(0, 255)));
			if (sel >= 20 && sel < 35) begin
				body[0] = 8'($urandom_range(0, 255));
				body[1] = 8'($urandom_range(0, 255));
			end
		end
		repeat ($urandom_range(0, 4)) body.push_back(8'($urandom_range(0, 255)));
		blen = body.size();
		if (sel < 20)
			blen = (blen == 0) ? 0 : $urandom_range(0, blen - 1);
		// pad the length with zero groups now and then
		extra = $urandom_range(0, 3);
		for (k = 0; k <= extra; k++)
			frame_bytes.push_back(((k == 0) ? 8'(blen) : 8'h00) | ((k < extra) ? 8'h80 : 8'h00));
		for (k = 0; k < blen; k++)
			frame_bytes.push_back(body[k]);
	endtask

	task automatic check_field(input string name, input logic [27:0] exp_v, input logic [27:0] act_v);
		if (exp_v !== act_v) begin
			$display("%0t %s: expected %0h, actual %0h", $time, name, exp_v, act_v);
			mismatches++;
		end
	endtask

	always @(posedge clk) begin
		if (arst_n && result_valid && result_ready) begin
			if (parse_due.size() == 0) begin
				$display("%0t result with none expected: expected nothing, actual data_byte %0h",
					$time, data_byte);
				mismatches++;
			end else begin
				want = parse_due.pop_front();
				check_field("byte_class", 28'(want.byte_class), 28'(byte_class));
				check_field("data_byte", 28'(want.data_byte), 28'(data_byte));
				check_field("packet_kind", 28'(want.packet_kind), 28'(packet_kind));
				check_field("qos_level", 28'(want.qos_level), 28'(qos_level));
				check_field("remaining_length", want.remaining_length, remaining_length);
				check_field("packet_id", 28'(want.packet_id), 28'(packet_id));
				check_field("connack_code", 28'(want.connack_code), 28'(connack_code));
				check_field("topic_size", 28'(want.topic_size), 28'(topic_size));
				check_field("header_done", 28'(want.header_done), 28'(header_done));
				check_field("frame_end", 28'(want.frame_end), 28'(frame_end));
				check_field("frame_error", 28'(want.frame_error), 28'(frame_error));
			end
		end
	end

	// result side: short random stalls, one long hold-off on request
	initial begin
		@(posedge arst_n);
		forever begin
			@(posedge clk);
			if (hold_req) begin
				result_ready <= 1'b0;
				repeat (200) @(posedge clk);
				hold_req = 1'b0;
				result_ready <= 1'b1;
			end else if (!no_idle && $urandom_range(0, 9) == 0) begin
				result_ready <= 1'b0;
				repeat ($urandom_range(1, 19)) @(posedge clk);
				result_ready <= 1'b1;
			end else begin
				result_ready <= 1'b1;
			end
		end
	end

	initial begin
		int i;
		int sent;
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		for (i = 0; i < DIR_ROWS; i++)
			put_byte(dir_rows[i].b, dir_rows[i].pinned, dir_rows[i].res);
		drain_results();
		sent = 0;
		while (sent < RANDOM_BYTES) begin
			make_frame();
			while (frame_bytes.size() != 0) begin
				if (sent == 100)
					hold_req = 1'b1;
				if (sent == 300)
					drain_results();
				if (sent >= RANDOM_BYTES - 100)
					no_idle = 1'b1;
				put_byte(frame_bytes.pop_front(), 1'b0, '0);
				sent++;
			end
		end
		drain_results();
		repeat (8) @(posedge clk);
		if (mismatches == 0)
			$display("All tests passed");
		else
			$display("Some tests failed");
		$finish;
	end

	initial begin
		#2000000;
		$display("Some tests failed");
		$finish;
	end

endmodule
